>>> src/http2_frame_splitter_macros.svh
// ----------------------------------------------------------------------------
// HTTP/2 frame splitter assertion macros
// Shorthand for the concurrent checks used in the splitter RTL. Each macro
// expects signals named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef HTTP2_FRAME_SPLITTER_MACROS_SVH
`define HTTP2_FRAME_SPLITTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define H2FS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define H2FS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/h2fs_pkg.sv
// ----------------------------------------------------------------------------
// HTTP/2 frame splitter package
// Phase and result codes, frame type and flag constants, result record.
// ----------------------------------------------------------------------------
package h2fs_pkg;

  // Parser phase within the connection stream
  typedef enum logic [2:0] {
    PH_HDR    = 3'd0,
    PH_PADLEN = 3'd1,
    PH_PRIO   = 3'd2,
    PH_BODY   = 3'd3,
    PH_PAD    = 3'd4,
    PH_SET    = 3'd5,
    PH_WIN    = 3'd6
  } phase_t;

  // Result kind, carried on tuser
  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_CONTENT   = 3'd1,
    KIND_SETTING   = 3'd2,
    KIND_WINDOW    = 3'd3,
    KIND_FRAME_END = 3'd4,
    KIND_ERROR     = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ERR_PROTOCOL   = 2'd0,
    ERR_FRAME_SIZE = 2'd1,
    ERR_BAD_MSG    = 2'd2,
    ERR_FIELDS     = 2'd3
  } err_t;

  // Frame types handled by the parser
  localparam logic [7:0] TYPE_DATA     = 8'd0;
  localparam logic [7:0] TYPE_HEADERS  = 8'd1;
  localparam logic [7:0] TYPE_SETTINGS = 8'd4;
  localparam logic [7:0] TYPE_WINDOW   = 8'd8;
  localparam logic [7:0] TYPE_MAX      = 8'd9;

  // Flag bit positions
  localparam int FL_ACK_BIT      = 0;
  localparam int FL_PADDED_BIT   = 3;
  localparam int FL_PRIORITY_BIT = 5;

  localparam logic [23:0] HDR_BYTES     = 24'd9;
  localparam logic [2:0]  SETTING_BYTES = 3'd6;
  localparam logic [2:0]  WINDOW_BYTES  = 3'd4;
  localparam logic [2:0]  PRIO_BYTES    = 3'd5;
  localparam logic [23:0] WINDOW_LEN    = 24'd4;

  localparam int TDATA_W = 160;
  localparam int TUSER_W = 3;

  typedef struct packed {
    kind_t        kind;
    logic [3:0]   frame_type;
    logic [7:0]   frame_flags;
    logic [30:0]  stream_id;
    logic [23:0]  frame_length;
    logic [7:0]   content_byte;
    logic [15:0]  setting_id;
    logic [31:0]  setting_value;
    logic [30:0]  window_increment;
    err_t         error_code;
    logic         frame_end;
  } result_t;

endpackage

>>> src/http2_frame_splitter.sv
// ----------------------------------------------------------------------------
// HTTP/2 frame splitter
// Deframes an HTTP/2 connection byte stream into headers, content bytes,
// SETTINGS entries, window increments, frame ends and errors.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave channel (in_*): one connection byte per transaction on in_tdata.
//  - Master channel (out_*): at most one result transaction per input byte.
//    out_tuser carries the result kind, out_tlast marks the result that
//    closes a frame, out_tdata carries the frame header fields and payload.
//  - Path: an accepted byte passes the input register, then the result
//    register, before its result reaches the outputs.
//  - Throughput: one byte per cycle unless a held result stalls; the parser state update is a single
//    pass of logic between the input register and the result register.
//  - Bytes that produce no result (header bytes 1-8, padding, priority,
//    partial SETTINGS/WINDOW_UPDATE entries) simply vanish.
//  - Stall: while out_tready is low and a result is held, the parser stops
//    and in_tready drops once the input register is full; nothing is lost.
//  - After any error result the block swallows all further input until
//    reset. Synchronous reset (rst_n low) clears the parser to header
//    collection and empties both registers.
// ----------------------------------------------------------------------------
module http2_frame_splitter (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] stream_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // [3:0] frame_type, [11:4] frame_flags,
                                   // [42:12] stream_id, [66:43] frame_length,
                                   // [74:67] content_byte, [90:75] setting_id,
                                   // [122:91] setting_value,
                                   // [153:123] window_increment,
                                   // [155:154] error_code, [159:156] zero
  output logic [2:0]   out_tuser,  // [2:0] kind
  output logic         out_tlast   // frame_end
);

  logic              hold_valid;
  logic [7:0]        hold_byte;
  logic              space;
  logic              step;
  logic              res_valid;
  h2fs_pkg::result_t res;
  h2fs_pkg::result_t out_res;

  // parser advances when a byte is held and the result register has room
  assign step = hold_valid && space;

  h2fs_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .take       (step),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  h2fs_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .in_byte   (hold_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  h2fs_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res_valid),
    .res       (res),
    .out_ready (out_tready),
    .space     (space),
    .out_valid (out_tvalid),
    .out_res   (out_res)
  );

  assign out_tdata = {4'h0,
                      out_res.error_code,
                      out_res.window_increment,
                      out_res.setting_value,
                      out_res.setting_id,
                      out_res.content_byte,
                      out_res.frame_length,
                      out_res.stream_id,
                      out_res.frame_flags,
                      out_res.frame_type};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.frame_end;

endmodule

>>> src/h2fs_in_reg.sv
// ----------------------------------------------------------------------------
// HTTP/2 frame splitter input register
// Holds one received stream byte until the parser takes it.
// ----------------------------------------------------------------------------
module h2fs_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       take,
  output logic       hold_valid,
  output logic [7:0] hold_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;

  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

endmodule

>>> src/h2fs_parser.sv
// ----------------------------------------------------------------------------
// HTTP/2 frame splitter parser
// Frame state and single-byte next-state logic; at most one result per byte.
// ----------------------------------------------------------------------------
`include "http2_frame_splitter_macros.svh"

module h2fs_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        in_byte,
  output logic              res_valid,
  output h2fs_pkg::result_t res
);

  h2fs_pkg::phase_t phase_r, phase_nxt;
  logic [23:0] byte_count_r, byte_count_nxt;
  logic [23:0] length_r, length_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [30:0] stream_r, stream_nxt;
  logic [7:0]  pad_count_r, pad_count_nxt;
  logic [47:0] accum_r, accum_nxt;
  logic [2:0]  entry_bytes_r, entry_bytes_nxt;
  logic        halted_r, halted_nxt;
  logic [1:0]  len_mod3_r, len_mod3_nxt;

  logic [23:0] bc;
  logic        last;
  logic        prio, padded;
  logic [2:0]  opt;
  logic [23:0] skip, room;
  logic [47:0] acc_new;

  // Running residue mod 3; 256 and 4 are both 1 mod 3, so fold 2-bit digits
  function automatic logic [1:0] mod3_add(input logic [1:0] acc, input logic [7:0] v);
    logic [3:0] s;
    logic [2:0] t;
    logic [2:0] u;
    logic [1:0] w;
    s = {2'b00, acc} + {2'b00, v[1:0]} + {2'b00, v[3:2]} + {2'b00, v[5:4]}
        + {2'b00, v[7:6]};
    t = {1'b0, s[3:2]} + {1'b0, s[1:0]};
    u = {2'b00, t[2]} + {1'b0, t[1:0]};
    w = {1'b0, u[2]} + u[1:0];
    return (w == 2'd3) ? 2'd0 : w;
  endfunction

  // Phase once the pad-length and priority fields are consumed
  function automatic h2fs_pkg::phase_t after_fields(input logic [23:0] left,
                                                    input logic [7:0] pad);
    if (left == 24'd0) begin
      return h2fs_pkg::PH_HDR;
    end else if (left > {16'h0, pad}) begin
      return h2fs_pkg::PH_BODY;
    end else begin
      return h2fs_pkg::PH_PAD;
    end
  endfunction

  assign bc      = byte_count_r - 24'd1;
  assign last    = (bc == 24'd0);
  assign acc_new = {accum_r[39:0], in_byte};

  always_comb begin
    phase_nxt       = phase_r;
    byte_count_nxt  = byte_count_r;
    length_nxt      = length_r;
    type_nxt        = type_r;
    flags_nxt       = flags_r;
    stream_nxt      = stream_r;
    pad_count_nxt   = pad_count_r;
    accum_nxt       = accum_r;
    entry_bytes_nxt = entry_bytes_r;
    halted_nxt      = halted_r;
    len_mod3_nxt    = len_mod3_r;
    res_valid       = 1'b0;
    res.kind             = h2fs_pkg::KIND_HEADER;
    res.content_byte     = 8'h0;
    res.setting_id       = 16'h0;
    res.setting_value    = 32'h0;
    res.window_increment = 31'h0;
    res.error_code       = h2fs_pkg::ERR_PROTOCOL;
    res.frame_end        = 1'b0;
    prio   = (type_r == h2fs_pkg::TYPE_HEADERS) && flags_r[h2fs_pkg::FL_PRIORITY_BIT];
    padded = (type_r <= h2fs_pkg::TYPE_HEADERS) && flags_r[h2fs_pkg::FL_PADDED_BIT];
    skip   = prio ? 24'd5 : 24'd0;
    room   = (bc >= skip) ? (bc - skip) : 24'd0;
    opt    = (padded ? 3'd1 : 3'd0) + (prio ? 3'd5 : 3'd0);

    if (step && !halted_r) begin
      case (phase_r)
        h2fs_pkg::PH_PADLEN: begin
          byte_count_nxt = bc;
          pad_count_nxt  = in_byte;
          if ({16'h0, in_byte} > room) begin
            halted_nxt     = 1'b1;
            res_valid      = 1'b1;
            res.kind       = h2fs_pkg::KIND_ERROR;
            res.error_code = h2fs_pkg::ERR_FIELDS;
          end else begin
            if (prio) begin
              phase_nxt       = h2fs_pkg::PH_PRIO;
              entry_bytes_nxt = 3'd0;
            end else begin
              phase_nxt = after_fields(bc, in_byte);
            end
            if (last) begin
              phase_nxt      = h2fs_pkg::PH_HDR;
              res_valid      = 1'b1;
              res.kind       = h2fs_pkg::KIND_FRAME_END;
              res.frame_end  = 1'b1;
            end
          end
        end
        h2fs_pkg::PH_PRIO: begin
          byte_count_nxt  = bc;
          entry_bytes_nxt = entry_bytes_r + 3'd1;
          if (entry_bytes_nxt >= h2fs_pkg::PRIO_BYTES) begin
            entry_bytes_nxt = 3'd0;
            phase_nxt       = after_fields(bc, pad_count_r);
          end
          if (last) begin
            phase_nxt     = h2fs_pkg::PH_HDR;
            res_valid     = 1'b1;
            res.kind      = h2fs_pkg::KIND_FRAME_END;
            res.frame_end = 1'b1;
          end
        end
        h2fs_pkg::PH_BODY: begin
          byte_count_nxt   = bc;
          res_valid        = 1'b1;
          res.kind         = h2fs_pkg::KIND_CONTENT;
          res.content_byte = in_byte;
          if (last) begin
            phase_nxt     = h2fs_pkg::PH_HDR;
            res.frame_end = 1'b1;
          end else if (bc <= {16'h0, pad_count_r}) begin
            phase_nxt = h2fs_pkg::PH_PAD;
          end
        end
        h2fs_pkg::PH_PAD: begin
          byte_count_nxt = bc;
          if (last) begin
            phase_nxt     = h2fs_pkg::PH_HDR;
            res_valid     = 1'b1;
            res.kind      = h2fs_pkg::KIND_FRAME_END;
            res.frame_end = 1'b1;
          end
        end
        h2fs_pkg::PH_SET, h2fs_pkg::PH_WIN: begin
          byte_count_nxt  = bc;
          accum_nxt       = acc_new;
          entry_bytes_nxt = entry_bytes_r + 3'd1;
          if ((phase_r == h2fs_pkg::PH_SET && entry_bytes_nxt >= h2fs_pkg::SETTING_BYTES) ||
              (phase_r == h2fs_pkg::PH_WIN && entry_bytes_nxt >= h2fs_pkg::WINDOW_BYTES)) begin
            entry_bytes_nxt = 3'd0;
            accum_nxt       = 48'h0;
            res_valid       = 1'b1;
            res.frame_end   = last;
            if (phase_r == h2fs_pkg::PH_SET) begin
              res.kind          = h2fs_pkg::KIND_SETTING;
              res.setting_id    = acc_new[47:32];
              res.setting_value = acc_new[31:0];
            end else begin
              res.kind             = h2fs_pkg::KIND_WINDOW;
              res.window_increment = acc_new[30:0];
            end
            if (last) begin
              phase_nxt = h2fs_pkg::PH_HDR;
            end
          end else if (last) begin
            phase_nxt     = h2fs_pkg::PH_HDR;
            res_valid     = 1'b1;
            res.kind      = h2fs_pkg::KIND_FRAME_END;
            res.frame_end = 1'b1;
          end
        end
        default: begin
          // header collection: length, type, flags, stream id
          if (byte_count_r < 24'd3) begin
            length_nxt   = {(byte_count_r == 24'd0) ? 16'h0 : length_r[15:0], in_byte};
            len_mod3_nxt = mod3_add((byte_count_r == 24'd0) ? 2'd0 : len_mod3_r, in_byte);
          end else if (byte_count_r == 24'd3) begin
            type_nxt = in_byte;
          end else if (byte_count_r == 24'd4) begin
            flags_nxt  = in_byte;
            stream_nxt = 31'h0;
          end else begin
            stream_nxt = {stream_r[22:0], in_byte};
          end
          byte_count_nxt = byte_count_r + 24'd1;
          if (byte_count_nxt >= h2fs_pkg::HDR_BYTES) begin
            byte_count_nxt = 24'd0;
            phase_nxt      = h2fs_pkg::PH_HDR;
            res_valid      = 1'b1;
            res.kind       = h2fs_pkg::KIND_ERROR;
            halted_nxt     = 1'b1;
            if (type_nxt > h2fs_pkg::TYPE_MAX) begin
              res.error_code = h2fs_pkg::ERR_BAD_MSG;
            end else if (type_nxt == h2fs_pkg::TYPE_SETTINGS && stream_nxt != 31'h0) begin
              res.error_code = h2fs_pkg::ERR_PROTOCOL;
            end else if (type_nxt == h2fs_pkg::TYPE_SETTINGS &&
                         flags_nxt[h2fs_pkg::FL_ACK_BIT] && length_nxt != 24'h0) begin
              res.error_code = h2fs_pkg::ERR_FRAME_SIZE;
            end else if (type_nxt == h2fs_pkg::TYPE_SETTINGS &&
                         (length_nxt[0] || len_mod3_nxt != 2'd0)) begin
              res.error_code = h2fs_pkg::ERR_FRAME_SIZE;
            end else if (type_nxt == h2fs_pkg::TYPE_WINDOW &&
                         length_nxt != h2fs_pkg::WINDOW_LEN) begin
              res.error_code = h2fs_pkg::ERR_FRAME_SIZE;
            end else if (!(type_nxt inside {h2fs_pkg::TYPE_DATA, h2fs_pkg::TYPE_HEADERS,
                                            h2fs_pkg::TYPE_SETTINGS, h2fs_pkg::TYPE_WINDOW})) begin
              res.error_code = h2fs_pkg::ERR_BAD_MSG;
            end else if (length_nxt < {21'h0, opt}) begin
              res.error_code = h2fs_pkg::ERR_FIELDS;
            end else begin
              // header accepted
              halted_nxt      = 1'b0;
              res.kind        = h2fs_pkg::KIND_HEADER;
              pad_count_nxt   = 8'h0;
              accum_nxt       = 48'h0;
              entry_bytes_nxt = 3'd0;
              if (length_nxt == 24'h0) begin
                res.frame_end = 1'b1;
              end else begin
                byte_count_nxt = length_nxt;
                if (padded) begin
                  phase_nxt = h2fs_pkg::PH_PADLEN;
                end else if (prio) begin
                  phase_nxt = h2fs_pkg::PH_PRIO;
                end else if (type_nxt == h2fs_pkg::TYPE_SETTINGS) begin
                  phase_nxt = h2fs_pkg::PH_SET;
                end else if (type_nxt == h2fs_pkg::TYPE_WINDOW) begin
                  phase_nxt = h2fs_pkg::PH_WIN;
                end else begin
                  phase_nxt = h2fs_pkg::PH_BODY;
                end
              end
            end
          end
        end
      endcase
    end

    // header fields of the current frame travel with every result
    res.frame_type   = (type_nxt <= h2fs_pkg::TYPE_MAX) ? type_nxt[3:0] : 4'h0;
    res.frame_flags  = flags_nxt;
    res.stream_id    = stream_nxt;
    res.frame_length = length_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= h2fs_pkg::PH_HDR;
      byte_count_r  <= 24'h0;
      length_r      <= 24'h0;
      type_r        <= 8'h0;
      flags_r       <= 8'h0;
      stream_r      <= 31'h0;
      pad_count_r   <= 8'h0;
      accum_r       <= 48'h0;
      entry_bytes_r <= 3'd0;
      halted_r      <= 1'b0;
      len_mod3_r    <= 2'd0;
    end else begin
      phase_r       <= phase_nxt;
      byte_count_r  <= byte_count_nxt;
      length_r      <= length_nxt;
      type_r        <= type_nxt;
      flags_r       <= flags_nxt;
      stream_r      <= stream_nxt;
      pad_count_r   <= pad_count_nxt;
      accum_r       <= accum_nxt;
      entry_bytes_r <= entry_bytes_nxt;
      halted_r      <= halted_nxt;
      len_mod3_r    <= len_mod3_nxt;
    end
  end

  `H2FS_ASSERT_NEXT(a_halt_sticky, halted_r, halted_r, "halt state released before reset")
  `H2FS_ASSERT_NOW(a_halt_silent, halted_r, !res_valid, "result produced while halted")
  `H2FS_ASSERT_NEXT(a_err_halts, res_valid && res.kind == h2fs_pkg::KIND_ERROR, halted_r, "error did not halt parser")
  `H2FS_ASSERT_NOW(a_err_no_end, res_valid && res.kind == h2fs_pkg::KIND_ERROR, !res.frame_end, "error result marks frame end")
  `H2FS_ASSERT_NOW(a_hdr_count, phase_r == h2fs_pkg::PH_HDR, byte_count_r < h2fs_pkg::HDR_BYTES, "header byte count out of range")

endmodule

>>> src/h2fs_out_reg.sv
// ----------------------------------------------------------------------------
// HTTP/2 frame splitter result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module h2fs_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  h2fs_pkg::result_t res,
  input  logic              out_ready,
  output logic              space,
  output logic              out_valid,
  output h2fs_pkg::result_t out_res
);

  logic              valid_r, valid_nxt;
  h2fs_pkg::result_t res_r;

  // room for a new result when empty or when the held one leaves now
  assign space = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

>>> tb/http2_frame_splitter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTTP/2 frame splitter testbench
// Sends well-formed frames of every handled type byte by byte, with random
// payloads, padding and priority fields, under four idle/stall mixes. A
// scoreboard class predicts each result from the accepted bytes and checks
// the result channel in order. The run ends with one malformed frame that
// halts the block, followed by bytes that must be swallowed.
// ----------------------------------------------------------------------------
module http2_frame_splitter_tb;
  import h2fs_pkg::*;

  // Flag masks built from the package bit positions
  localparam logic [7:0] FLAG_ACK      = 8'h01 << FL_ACK_BIT;
  localparam logic [7:0] FLAG_PADDED   = 8'h01 << FL_PADDED_BIT;
  localparam logic [7:0] FLAG_PRIORITY = 8'h01 << FL_PRIORITY_BIT;

  // Frame types the block rejects as unsupported
  localparam logic [7:0] TYPE_PRIORITY      = 8'd2;
  localparam logic [7:0] TYPE_RST_STREAM    = 8'd3;
  localparam logic [7:0] TYPE_PUSH_PROMISE  = 8'd5;
  localparam logic [7:0] TYPE_PING          = 8'd6;
  localparam logic [7:0] TYPE_GOAWAY        = 8'd7;
  localparam logic [7:0] TYPE_CONTINUATION  = TYPE_MAX;

  localparam int BYTES_PER_PHASE = 225;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the deframer state per accepted byte and holds the
  // results still owed by the block.
  // --------------------------------------------------------------------------
  class deframe_scoreboard;
    result_t     owed_results[$];
    int          mismatches = 0;

    phase_t      phase    = PH_HDR;
    logic [23:0] byte_cnt = '0;   // header bytes seen, or payload bytes left
    logic [23:0] frame_len = '0;
    logic [7:0]  ftype    = '0;
    logic [7:0]  fflags   = '0;
    logic [30:0] sid      = '0;
    logic [7:0]  pad_len  = '0;
    logic [47:0] entry    = '0;
    logic [2:0]  entry_n  = '0;
    bit          halted   = 1'b0;

    function int pending();
      return owed_results.size();
    endfunction

    function bit has_prio();
      return (ftype == TYPE_HEADERS) && fflags[FL_PRIORITY_BIT];
    endfunction

    function bit has_pad();
      return (ftype <= TYPE_HEADERS) && fflags[FL_PADDED_BIT];
    endfunction

    // Every result carries the current header; type above 9 reads as 0
    function result_t pack_result(kind_t k, logic [7:0] cb, logic [15:0] id,
                                  logic [31:0] val, logic [30:0] inc, err_t err,
                                  logic endf);
      result_t r;
      r.kind             = k;
      r.frame_type       = (ftype <= TYPE_MAX) ? ftype[3:0] : 4'd0;
      r.frame_flags      = fflags;
      r.stream_id        = sid;
      r.frame_length     = frame_len;
      r.content_byte     = cb;
      r.setting_id       = id;
      r.setting_value    = val;
      r.window_increment = inc;
      r.error_code       = err;
      r.frame_end        = endf;
      return r;
    endfunction

    function bit raise_error(err_t code, output result_t r);
      halted = 1'b1;
      r = pack_result(KIND_ERROR, '0, '0, '0, '0, code, 1'b0);
      return 1'b1;
    endfunction

    function bit close_frame(output result_t r);
      phase    = PH_HDR;
      byte_cnt = '0;
      r = pack_result(KIND_FRAME_END, '0, '0, '0, '0, ERR_PROTOCOL, 1'b1);
      return 1'b1;
    endfunction

    // Where to go once pad length and priority fields are consumed
    function void after_fields();
      if (byte_cnt == 0) phase = PH_HDR;
      else if (byte_cnt > pad_len) phase = PH_BODY;
      else phase = PH_PAD;
    endfunction

    // Header checks, in priority order
    function bit header_done(output result_t r);
      logic [23:0] opt;
      opt      = (has_pad() ? 24'd1 : 24'd0) + (has_prio() ? 24'(PRIO_BYTES) : 24'd0);
      byte_cnt = '0;
      phase    = PH_HDR;
      if (ftype > TYPE_MAX) return raise_error(ERR_BAD_MSG, r);
      if (ftype == TYPE_SETTINGS) begin
        if (sid != 0) return raise_error(ERR_PROTOCOL, r);
        if (fflags[FL_ACK_BIT] && frame_len != 0) return raise_error(ERR_FRAME_SIZE, r);
        if (frame_len % SETTING_BYTES != 0) return raise_error(ERR_FRAME_SIZE, r);
      end
      if (ftype == TYPE_WINDOW && frame_len != WINDOW_LEN)
        return raise_error(ERR_FRAME_SIZE, r);
      if (ftype != TYPE_DATA && ftype != TYPE_HEADERS && ftype != TYPE_SETTINGS &&
          ftype != TYPE_WINDOW)
        return raise_error(ERR_BAD_MSG, r);
      if (frame_len < opt) return raise_error(ERR_FIELDS, r);

      pad_len = '0;
      entry   = '0;
      entry_n = '0;
      if (frame_len == 0) begin
        r = pack_result(KIND_HEADER, '0, '0, '0, '0, ERR_PROTOCOL, 1'b1);
        return 1'b1;
      end
      byte_cnt = frame_len;
      if (has_pad()) phase = PH_PADLEN;
      else if (has_prio()) phase = PH_PRIO;
      else if (ftype == TYPE_SETTINGS) phase = PH_SET;
      else if (ftype == TYPE_WINDOW) phase = PH_WIN;
      else phase = PH_BODY;
      r = pack_result(KIND_HEADER, '0, '0, '0, '0, ERR_PROTOCOL, 1'b0);
      return 1'b1;
    endfunction

    // One connection byte in, at most one result out
    function bit deframe_byte(logic [7:0] b, output result_t r);
      logic        last;
      logic [23:0] skip;
      logic [23:0] room;
      logic [30:0] inc;
      r = '0;
      if (halted) return 1'b0;

      if (phase == PH_HDR) begin
        if (byte_cnt < 3) begin
          if (byte_cnt == 0) frame_len = '0;
          frame_len = {frame_len[15:0], b};
        end else if (byte_cnt == 3) begin
          ftype = b;
        end else if (byte_cnt == 4) begin
          fflags = b;
          sid    = '0;
        end else begin
          sid = {sid[22:0], b};   // reserved bit falls off the top
        end
        byte_cnt++;
        if (byte_cnt >= HDR_BYTES) return header_done(r);
        return 1'b0;
      end

      byte_cnt = byte_cnt - 1;
      last     = (byte_cnt == 0);

      case (phase)
        PH_PADLEN: begin
          skip    = has_prio() ? 24'(PRIO_BYTES) : 24'd0;
          room    = (byte_cnt >= skip) ? byte_cnt - skip : 24'd0;
          pad_len = b;
          if (24'(b) > room) return raise_error(ERR_FIELDS, r);
          if (has_prio()) begin
            phase   = PH_PRIO;
            entry_n = '0;
          end else begin
            after_fields();
          end
          if (last) return close_frame(r);
          return 1'b0;
        end
        PH_PRIO: begin
          entry_n++;
          if (entry_n >= PRIO_BYTES) begin
            entry_n = '0;
            after_fields();
          end
          if (last) return close_frame(r);
          return 1'b0;
        end
        PH_BODY: begin
          if (last) begin
            phase = PH_HDR;
            r = pack_result(KIND_CONTENT, b, '0, '0, '0, ERR_PROTOCOL, 1'b1);
            return 1'b1;
          end
          if (byte_cnt <= pad_len) phase = PH_PAD;
          r = pack_result(KIND_CONTENT, b, '0, '0, '0, ERR_PROTOCOL, 1'b0);
          return 1'b1;
        end
        PH_PAD: begin
          if (last) return close_frame(r);
          return 1'b0;
        end
        PH_SET: begin
          entry = {entry[39:0], b};
          entry_n++;
          if (entry_n >= SETTING_BYTES) begin
            r = pack_result(KIND_SETTING, '0, entry[47:32], entry[31:0], '0,
                            ERR_PROTOCOL, last);
            entry   = '0;
            entry_n = '0;
            if (last) phase = PH_HDR;
            return 1'b1;
          end
          if (last) return close_frame(r);
          return 1'b0;
        end
        default: begin
          entry = {entry[39:0], b};
          entry_n++;
          if (entry_n >= WINDOW_BYTES) begin
            inc = entry[30:0];
            r = pack_result(KIND_WINDOW, '0, '0, '0, inc, ERR_PROTOCOL, last);
            entry   = '0;
            entry_n = '0;
            if (last) phase = PH_HDR;
            return 1'b1;
          end
          if (last) return close_frame(r);
          return 1'b0;
        end
      endcase
    endfunction

    function void note_input(logic [7:0] b);
      result_t r;
      if (deframe_byte(b, r)) owed_results.push_back(r);
    endfunction

    function string show(result_t r);
      return $sformatf({"kind=%0d type=%0d flags=%h sid=%h len=%h byte=%h ",
                        "id=%h val=%h inc=%h err=%0d end=%0d"},
                       r.kind, r.frame_type, r.frame_flags, r.stream_id,
                       r.frame_length, r.content_byte, r.setting_id,
                       r.setting_value, r.window_increment, r.error_code,
                       r.frame_end);
    endfunction

    function void check_result(logic [159:0] data, logic [2:0] user, logic endf);
      result_t got;
      result_t want;
      got.kind             = kind_t'(user);
      got.frame_type       = data[3:0];
      got.frame_flags      = data[11:4];
      got.stream_id        = data[42:12];
      got.frame_length     = data[66:43];
      got.content_byte     = data[74:67];
      got.setting_id       = data[90:75];
      got.setting_value    = data[122:91];
      got.window_increment = data[153:123];
      got.error_code       = err_t'(data[155:154]);
      got.frame_end        = endf;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing owed: %s", $realtime, show(got));
        return;
      end
      want = owed_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;    // [7:0] stream_byte
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [159:0] out_tdata;        // frame_type up to error_code, see DUT ports
  logic [2:0]   out_tuser;        // [2:0] kind
  logic         out_tlast;        // frame_end

  always #5 clk = ~clk;

  http2_frame_splitter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  deframe_scoreboard deframe_sb = new;

  int          send_idle_pct  = 0;   // chance per cycle that the sender holds off
  int          recv_stall_pct = 0;   // chance per cycle that the receiver stalls
  int          bytes_sent     = 0;
  logic [7:0]  wire_bytes[$];        // bytes of the frames queued for sending

  // Receiver: tready re-rolled every falling edge
  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Result monitor: one transaction per edge with tvalid and tready high
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      deframe_sb.check_result(out_tdata, out_tuser, out_tlast);
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Frame building
  // --------------------------------------------------------------------------
  function void push_fill(int n, logic [7:0] v);
    repeat (n) wire_bytes.push_back(v);
  endfunction

  function void push_random(int n);
    repeat (n) wire_bytes.push_back(8'($urandom));
  endfunction

  // sid_word carries the reserved bit on top
  function void push_header(logic [23:0] len, logic [7:0] ftype, logic [7:0] flags,
                            logic [31:0] sid_word);
    wire_bytes.push_back(len[23:16]);
    wire_bytes.push_back(len[15:8]);
    wire_bytes.push_back(len[7:0]);
    wire_bytes.push_back(ftype);
    wire_bytes.push_back(flags);
    wire_bytes.push_back(sid_word[31:24]);
    wire_bytes.push_back(sid_word[23:16]);
    wire_bytes.push_back(sid_word[15:8]);
    wire_bytes.push_back(sid_word[7:0]);
  endfunction

  // DATA or HEADERS with optional pad length, priority fields and padding
  function void add_content_frame(logic [7:0] ftype, logic [7:0] flags, int body,
                                  int pad, logic [31:0] sid_word);
    bit padded;
    bit prio;
    int len;
    padded = flags[FL_PADDED_BIT];
    prio   = (ftype == TYPE_HEADERS) && flags[FL_PRIORITY_BIT];
    if (!padded) pad = 0;
    len = (padded ? 1 + pad : 0) + (prio ? int'(PRIO_BYTES) : 0) + body;
    push_header(24'(len), ftype, flags, sid_word);
    if (padded) wire_bytes.push_back(8'(pad));
    if (prio) push_random(PRIO_BYTES);
    push_random(body);
    push_random(pad);
  endfunction

  function void add_random_frame();
    logic [7:0] flags;
    int         body;
    int         pad;
    int         n;
    flags = 8'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        // mostly short payloads, now and then a long body or long padding
        body = ($urandom_range(19) == 0) ? $urandom_range(300, 40) : $urandom_range(12, 0);
        pad  = ($urandom_range(19) == 0) ? $urandom_range(255, 128) : $urandom_range(6, 0);
        add_content_frame(($urandom_range(1) != 0) ? TYPE_HEADERS : TYPE_DATA, flags,
                          body, pad, $urandom);
      end
      6, 7: begin
        n = flags[FL_ACK_BIT] ? 0 : $urandom_range(3, 0);
        push_header(24'(n * SETTING_BYTES), TYPE_SETTINGS, flags,
                    {1'($urandom_range(1)), 31'd0});
        push_random(n * SETTING_BYTES);
      end
      default: begin
        push_header(WINDOW_LEN, TYPE_WINDOW, flags, $urandom);
        push_random(WINDOW_LEN);
      end
    endcase
  endfunction

  // One malformed frame; the block stops after it, so this is the last one
  function void add_broken_frame();
    logic [7:0]  flags;
    logic [7:0]  ftype;
    logic [31:0] sid_word;
    int          len;
    int          opt;
    int          body;
    flags    = 8'($urandom);
    sid_word = $urandom;
    case ($urandom_range(7))
      0: begin  // type above CONTINUATION
        len = $urandom_range(8, 0);
        push_header(24'(len), 8'($urandom_range(255, 10)), flags, sid_word);
        push_random(len);
      end
      1: begin  // SETTINGS on a stream
        sid_word = {1'($urandom_range(1)), 31'($urandom_range(32'h7FFF_FFFF, 1))};
        len = $urandom_range(2, 0) * SETTING_BYTES;
        push_header(24'(len), TYPE_SETTINGS, flags, sid_word);
        push_random(len);
      end
      2: begin  // SETTINGS ACK with a payload
        len = $urandom_range(3, 1) * SETTING_BYTES;
        push_header(24'(len), TYPE_SETTINGS, flags | FLAG_ACK, {sid_word[31], 31'd0});
        push_random(len);
      end
      3: begin  // SETTINGS length not a whole number of entries
        len = $urandom_range(2, 0) * SETTING_BYTES + $urandom_range(5, 1);
        push_header(24'(len), TYPE_SETTINGS, flags & ~FLAG_ACK, {sid_word[31], 31'd0});
        push_random(len);
      end
      4: begin  // WINDOW_UPDATE of the wrong size
        len = $urandom_range(7, 0);
        if (len >= WINDOW_LEN) len++;
        push_header(24'(len), TYPE_WINDOW, flags, sid_word);
        push_random(len);
      end
      5: begin  // known but unsupported type
        case ($urandom_range(5))
          0: ftype = TYPE_PRIORITY;
          1: ftype = TYPE_RST_STREAM;
          2: ftype = TYPE_PUSH_PROMISE;
          3: ftype = TYPE_PING;
          4: ftype = TYPE_GOAWAY;
          default: ftype = TYPE_CONTINUATION;
        endcase
        len = $urandom_range(8, 0);
        push_header(24'(len), ftype, flags, sid_word);
        push_random(len);
      end
      6: begin  // too short for its pad length / priority fields
        if ($urandom_range(1) != 0) begin
          push_header(24'd0, TYPE_DATA, flags | FLAG_PADDED, sid_word);
        end else begin
          flags = flags | FLAG_PRIORITY;
          opt   = (flags[FL_PADDED_BIT] ? 1 : 0) + PRIO_BYTES;
          len   = $urandom_range(opt - 1, 0);
          push_header(24'(len), TYPE_HEADERS, flags, sid_word);
          push_random(len);
        end
      end
      default: begin  // pad length larger than what is left
        ftype = ($urandom_range(1) != 0) ? TYPE_HEADERS : TYPE_DATA;
        flags = flags | FLAG_PADDED;
        opt   = (ftype == TYPE_HEADERS && flags[FL_PRIORITY_BIT]) ? int'(PRIO_BYTES) : 0;
        body  = $urandom_range(8, 0);
        len   = 1 + opt + body;
        push_header(24'(len), ftype, flags, sid_word);
        wire_bytes.push_back(8'($urandom_range(255, body + 1)));
        push_random(len - 1);
      end
    endcase
    push_random(16);  // trailing bytes the halted block must swallow
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  // Called at a falling edge, returns at a falling edge
  task automatic send_byte(logic [7:0] b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    deframe_sb.note_input(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_queued();
    while (wire_bytes.size() != 0) send_byte(wire_bytes.pop_front());
  endtask

  // Sender goes quiet until every owed result has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    while (deframe_sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames, no idling
    push_header(24'd0, TYPE_DATA, 8'h00, 32'h0000_0001);                // empty payload
    add_content_frame(TYPE_DATA, 8'hF7, 0, 0, 32'hFFFF_FFFF);          // header only, flags
    push_header(24'd3, TYPE_DATA, ~FLAG_PADDED, 32'h8000_0000);
    wire_bytes.push_back(8'h00);
    wire_bytes.push_back(8'hFF);
    wire_bytes.push_back(8'h5A);
    add_content_frame(TYPE_DATA, FLAG_PADDED, 0, 2, 32'h0000_0003);     // ends in padding
    add_content_frame(TYPE_DATA, FLAG_PADDED, 0, 0, 32'h0000_0005);     // ends on pad length
    add_content_frame(TYPE_HEADERS, FLAG_PRIORITY, 0, 0, 32'h0000_0007); // ends in priority
    add_content_frame(TYPE_HEADERS, 8'hFF, 2, 1, 32'h7FFF_FFFF);
    push_header(24'd0, TYPE_SETTINGS, FLAG_ACK, 32'h8000_0000);         // SETTINGS ACK
    push_header(24'd12, TYPE_SETTINGS, ~FLAG_ACK, 32'h0000_0000);
    push_fill(SETTING_BYTES, 8'hFF);
    push_fill(SETTING_BYTES, 8'h00);
    push_header(WINDOW_LEN, TYPE_WINDOW, 8'h00, 32'h0000_0000);         // reserved bit dropped
    push_fill(WINDOW_LEN, 8'hFF);
    push_header(WINDOW_LEN, TYPE_WINDOW, 8'hFF, 32'hFFFF_FFFF);
    push_fill(WINDOW_LEN, 8'h00);
    send_queued();
    drain();

    // Random frames under each idle/stall mix, draining between mixes
    for (int mix = 0; mix < 4; mix++) begin
      case (mix)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      bytes_sent = 0;
      while (bytes_sent < BYTES_PER_PHASE) begin
        add_random_frame();
        send_queued();
      end
      drain();
    end

    // Malformed frame last: error, then everything is swallowed
    add_broken_frame();
    send_queued();
    drain();
    repeat (20) @(posedge clk);

    if (deframe_sb.mismatches == 0 && deframe_sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/h2fs_pkg.sv
src/h2fs_in_reg.sv
src/h2fs_parser.sv
src/h2fs_out_reg.sv
src/http2_frame_splitter.sv
tb/http2_frame_splitter_tb.sv
